FILE: sv/bidu_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Bilinear downscaler package
// Shared constants, sequencer states and the control group that the
// sequencer sends to the coordinate units and the channel lanes.
// ============================================================================
package bidu_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int STEP_W      = 24;
  localparam int SIZE_W      = 8;
  localparam int SRC_COORD_W = 7;
  localparam int DST_COORD_W = 12;
  localparam int PIXEL_W     = 32;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HSTEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VSTEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'h010000;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd128;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPLIT,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_LERP_H,
    ST_LERP_V,
    ST_OUT
  } bidu_state_t;

  typedef struct packed {
    logic coord_en;
    logic split_en;
    logic lerp_h_en;
    logic lerp_v_en;
  } bidu_ctrl_t;

endpackage

FILE: sv/bidu_coord.sv
`timescale 1ns / 1ps
// ============================================================================
// Bilinear downscaler coordinate unit
// Scales one target coordinate by a fixed-point step, then splits the
// position into a saturated neighbour pair and a fraction.
// ============================================================================
module bidu_coord #(
  parameter int LIM_MAX   = bidu_pkg::MAX_WIDTH_DEF,
  parameter int FRAC_BITS = bidu_pkg::FRAC_BITS_DEF,
  localparam int IDX_W    = $clog2(LIM_MAX)
) (
  input  logic                               clk,
  input  bidu_pkg::bidu_ctrl_t               ctrl,
  input  logic [bidu_pkg::DST_COORD_W-1:0]   coord,
  input  logic [bidu_pkg::STEP_W-1:0]        step,
  input  logic [bidu_pkg::SIZE_W-1:0]        size,
  output logic [IDX_W-1:0]                   i0,
  output logic [IDX_W-1:0]                   i1,
  output logic [FRAC_BITS-1:0]               frac
);
  import bidu_pkg::*;

  localparam int PROD_W = DST_COORD_W + STEP_W;
  localparam int IP_W   = PROD_W - FRAC_BITS;
  localparam int LIM_W  = $clog2(LIM_MAX + 1);
  localparam int CMP_W  = ((IP_W > LIM_W) ? IP_W : LIM_W) + 1;

  logic [PROD_W-1:0]    prod_r;
  logic [IDX_W-1:0]     i0_r;
  logic [IDX_W-1:0]     i1_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [LIM_W-1:0]     limit;
  logic [CMP_W-1:0]     ip_ext;
  logic [CMP_W-1:0]     lim_ext;
  logic [CMP_W-1:0]     a_ext;
  logic [IDX_W-1:0]     a;
  logic [IDX_W-1:0]     a_inc;
  logic                 sat;
  logic                 has_next;

  always_comb begin
    priority if (size == '0) begin
      limit = LIM_W'(1);
    end else if (32'(size) > LIM_MAX) begin
      limit = LIM_W'(LIM_MAX);
    end else begin
      limit = LIM_W'(size);
    end
    ip_ext   = CMP_W'(prod_r[PROD_W-1:FRAC_BITS]);
    lim_ext  = CMP_W'(limit);
    sat      = (ip_ext >= lim_ext);
    a        = sat ? IDX_W'(limit - LIM_W'(1)) : IDX_W'(prod_r[PROD_W-1:FRAC_BITS]);
    a_ext    = CMP_W'(a) + CMP_W'(1);
    has_next = (a_ext < lim_ext);
    a_inc    = a + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.coord_en) begin
      prod_r <= PROD_W'(coord) * PROD_W'(step);
    end
    if (ctrl.split_en) begin
      i0_r   <= a;
      i1_r   <= has_next ? a_inc : a;
      frac_r <= prod_r[FRAC_BITS-1:0];
    end
  end

  assign i0   = i0_r;
  assign i1   = i1_r;
  assign frac = frac_r;

endmodule

FILE: sv/bidu_lane.sv
`timescale 1ns / 1ps
// ============================================================================
// Bilinear downscaler channel lane
// Interpolates one byte channel: a horizontal blend of both rows, then a
// vertical blend, then rounding half up to eight bits.
// ============================================================================
module bidu_lane #(
  parameter int FRAC_BITS = bidu_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  bidu_pkg::bidu_ctrl_t          ctrl,
  input  logic [bidu_pkg::CHAN_W-1:0]   p00,
  input  logic [bidu_pkg::CHAN_W-1:0]   p10,
  input  logic [bidu_pkg::CHAN_W-1:0]   p01,
  input  logic [bidu_pkg::CHAN_W-1:0]   p11,
  input  logic [FRAC_BITS-1:0]          fx,
  input  logic [FRAC_BITS-1:0]          fy,
  output logic [bidu_pkg::CHAN_W-1:0]   chan
);
  import bidu_pkg::*;

  localparam int H_W   = CHAN_W + FRAC_BITS;
  localparam int ACC_W = CHAN_W + 2 * FRAC_BITS;
  localparam logic [ACC_W:0] HALF = (ACC_W + 1)'(1) << (2 * FRAC_BITS - 1);

  logic signed [CHAN_W:0]  d0;
  logic signed [CHAN_W:0]  d1;
  logic signed [H_W+1:0]   m0;
  logic signed [H_W+1:0]   m1;
  logic signed [H_W+1:0]   s0;
  logic signed [H_W+1:0]   s1;
  logic [H_W-1:0]          h0_r;
  logic [H_W-1:0]          h1_r;
  logic signed [H_W:0]     dh;
  logic signed [ACC_W+1:0] mv;
  logic signed [ACC_W+1:0] sv;
  logic [ACC_W-1:0]        acc_r;
  logic [ACC_W:0]          rnd;

  always_comb begin
    d0  = $signed({1'b0, p10}) - $signed({1'b0, p00});
    d1  = $signed({1'b0, p11}) - $signed({1'b0, p01});
    m0  = d0 * $signed({1'b0, fx});
    m1  = d1 * $signed({1'b0, fx});
    s0  = $signed({2'b00, p00, {FRAC_BITS{1'b0}}}) + m0;
    s1  = $signed({2'b00, p01, {FRAC_BITS{1'b0}}}) + m1;
    dh  = $signed({1'b0, h1_r}) - $signed({1'b0, h0_r});
    mv  = dh * $signed({1'b0, fy});
    sv  = $signed({2'b00, h0_r, {FRAC_BITS{1'b0}}}) + mv;
    rnd = {1'b0, acc_r} + HALF;
  end

  always_ff @(posedge clk) begin
    if (ctrl.lerp_h_en) begin
      h0_r <= s0[H_W-1:0];
      h1_r <= s1[H_W-1:0];
    end
    if (ctrl.lerp_v_en) begin
      acc_r <= sv[ACC_W-1:0];
    end
  end

  assign chan = rnd[ACC_W-1:2*FRAC_BITS];

endmodule

FILE: sv/bilinear_image_downscaler_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// Bilinear image downscaler
// Stores a BGRA source frame and answers target pixel requests with
// bilinear interpolation over four byte-channel lanes.
// ============================================================================
// A write beat stores a pixel in the single-port frame store; it gives no
// result. A request beat, once accepted, goes through these steps until its
// pixel sits in the output register: multiply both coordinates by their
// steps, split them into neighbours and fractions, read the four neighbours
// one after another through the single store port, blend horizontally and
// then vertically in the four channel lanes, and merge the lanes into the
// output register. The next beat is taken in the cycle after that register
// is loaded, even while the result still waits, so a new request is taken
// only once the one before it has loaded its result. A request that
// finishes while an earlier result still waits holds in its last step
// until that result is taken. The frame store holds nothing defined after
// reset and needs no clearing pass: every location must be written before
// a request reads it. Configuration writes take effect at once and belong
// between beats.
module bilinear_image_downscaler_unit #(
  parameter int MAX_WIDTH  = bidu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bidu_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = bidu_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [bidu_pkg::SRC_COORD_W-1:0]    in_src_col,
  input  logic [bidu_pkg::SRC_COORD_W-1:0]    in_src_row,
  input  logic [bidu_pkg::PIXEL_W-1:0]        in_pixel_bgra,
  input  logic [bidu_pkg::DST_COORD_W-1:0]    in_dst_col,
  input  logic [bidu_pkg::DST_COORD_W-1:0]    in_dst_row,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bidu_pkg::PIXEL_W-1:0]        out_pixel,
  input  logic                                cfg_we,
  input  logic [bidu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bidu_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bidu_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);

  logic [STEP_W-1:0]      hstep_r;
  logic [STEP_W-1:0]      vstep_r;
  logic [SIZE_W-1:0]      width_r;
  logic [SIZE_W-1:0]      height_r;
  bidu_state_t            state_r;
  bidu_state_t            state_nxt;
  bidu_ctrl_t             ctrl;
  logic [DST_COORD_W-1:0] dst_col_r;
  logic [DST_COORD_W-1:0] dst_row_r;
  logic [PIXEL_W-1:0]     mem [DEPTH];
  logic [ADDR_W-1:0]      mem_addr;
  logic [ADDR_W-1:0]      wr_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   mem_we;
  logic                   wr_in_range;
  logic [PIXEL_W-1:0]     rd_data_r;
  logic [PIXEL_W-1:0]     p00_r;
  logic [PIXEL_W-1:0]     p10_r;
  logic [PIXEL_W-1:0]     p01_r;
  logic [XW-1:0]          x0;
  logic [XW-1:0]          x1;
  logic [YW-1:0]          y0;
  logic [YW-1:0]          y1;
  logic [XW-1:0]          rd_col;
  logic [YW-1:0]          rd_row;
  logic [FRAC_BITS-1:0]   fx;
  logic [FRAC_BITS-1:0]   fy;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] lane_chan;
  logic [PIXEL_W-1:0]     out_pixel_r;
  logic                   out_valid_r;
  logic                   out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hstep_r  <= STEP_RESET;
      vstep_r  <= STEP_RESET;
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HSTEP:  hstep_r  <= cfg_data;
        CFG_VSTEP:  vstep_r  <= cfg_data;
        CFG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    wr_in_range = (32'(in_src_col) < MAX_WIDTH) && (32'(in_src_row) < MAX_HEIGHT);
    state_nxt   = state_r;
    in_ready    = 1'b0;
    ctrl        = '0;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_REQUEST) begin
            state_nxt = ST_MUL;
          end else begin
            mem_we = wr_in_range;
          end
        end
      end
      ST_MUL: begin
        ctrl.coord_en = 1'b1;
        state_nxt     = ST_SPLIT;
      end
      ST_SPLIT: begin
        ctrl.split_en = 1'b1;
        state_nxt     = ST_RD0;
      end
      ST_RD0:    state_nxt = ST_RD1;
      ST_RD1:    state_nxt = ST_RD2;
      ST_RD2:    state_nxt = ST_RD3;
      ST_RD3:    state_nxt = ST_LERP_H;
      ST_LERP_H: begin
        ctrl.lerp_h_en = 1'b1;
        state_nxt      = ST_LERP_V;
      end
      ST_LERP_V: begin
        ctrl.lerp_v_en = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_RD1: begin
        rd_col = x1;
        rd_row = y0;
      end
      ST_RD2: begin
        rd_col = x0;
        rd_row = y1;
      end
      ST_RD3: begin
        rd_col = x1;
        rd_row = y1;
      end
      default: begin
        rd_col = x0;
        rd_row = y0;
      end
    endcase
    wr_addr  = ADDR_W'(in_src_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_src_col);
    rd_addr  = ADDR_W'(rd_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col);
    mem_addr = (state_r == ST_IDLE) ? wr_addr : rd_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_pixel_bgra;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      dst_col_r <= in_dst_col;
      dst_row_r <= in_dst_row;
    end
    if (state_r == ST_RD1) begin
      p00_r <= rd_data_r;
    end
    if (state_r == ST_RD2) begin
      p10_r <= rd_data_r;
    end
    if (state_r == ST_RD3) begin
      p01_r <= rd_data_r;
    end
    if (out_load) begin
      out_pixel_r <= lane_chan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  bidu_coord #(
    .LIM_MAX   (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_coord_x (
    .clk   (clk),
    .ctrl  (ctrl),
    .coord (dst_col_r),
    .step  (hstep_r),
    .size  (width_r),
    .i0    (x0),
    .i1    (x1),
    .frac  (fx)
  );

  bidu_coord #(
    .LIM_MAX   (MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_coord_y (
    .clk   (clk),
    .ctrl  (ctrl),
    .coord (dst_row_r),
    .step  (vstep_r),
    .size  (height_r),
    .i0    (y0),
    .i1    (y1),
    .frac  (fy)
  );

  // The lower-right neighbour is still in the read register when the lanes
  // start, so it goes straight in.
  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    bidu_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .p00  (p00_r[c*CHAN_W +: CHAN_W]),
      .p10  (p10_r[c*CHAN_W +: CHAN_W]),
      .p01  (p01_r[c*CHAN_W +: CHAN_W]),
      .p11  (rd_data_r[c*CHAN_W +: CHAN_W]),
      .fx   (fx),
      .fy   (fy),
      .chan (lane_chan[c])
    );
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

`ifndef SYNTHESIS
  a_req_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op == OP_REQUEST) |=> (state_r == ST_MUL))
    else $error("Accepted request did not start the coordinate multiply.");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("Result appeared without a finished request.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_valid_r && !out_ready) |=> (state_r == ST_OUT && out_valid_r))
    else $error("Finished request did not wait for the output register.");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !mem_we)
    else $error("Frame store written during a request.");
`endif

endmodule

FILE: verif/bilinear_image_downscaler_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Bilinear image downscaler unit test
// Writes BGRA source pixels and requests interpolated target pixels under a
// range of step and frame-size settings. The sender works in bursts with
// random gaps and the receiver stalls on a pattern of its own. Every result
// beat is checked against a fixed pixel or a bilinear predictor in the bench.
// ============================================================================
module bilinear_image_downscaler_unit_test;
  import bidu_pkg::*;

  localparam int STORE_DEPTH   = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int RUN_LIMIT_NS  = 20_000_000;
  localparam int DST_MAX       = (1 << DST_COORD_W) - 1;
  localparam logic [63:0] UNITY = 64'd1 << FRAC_BITS_DEF;
  localparam logic [63:0] HALF  = 64'd1 << (2 * FRAC_BITS_DEF - 1);

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_REQUEST,
    ROW_CONFIG
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [11:0]        a;
    logic [11:0]        b;
    logic [PIXEL_W-1:0] data;
    logic               has_exp;
    logic [PIXEL_W-1:0] exp_pixel;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_op;
  logic [SRC_COORD_W-1:0] in_src_col;
  logic [SRC_COORD_W-1:0] in_src_row;
  logic [PIXEL_W-1:0]     in_pixel_bgra;
  logic [DST_COORD_W-1:0] in_dst_col;
  logic [DST_COORD_W-1:0] in_dst_row;
  logic                   out_valid;
  logic                   out_ready;
  logic [PIXEL_W-1:0]     out_pixel;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic [PIXEL_W-1:0] frame_copy [STORE_DEPTH];
  bit                 pix_written [STORE_DEPTH];
  logic [STEP_W-1:0]  hstep_copy  = 24'h010000;
  logic [STEP_W-1:0]  vstep_copy  = 24'h010000;
  logic [SIZE_W-1:0]  width_copy  = SIZE_RESET;
  logic [SIZE_W-1:0]  height_copy = SIZE_RESET;
  logic [PIXEL_W-1:0] pending_pixels [$];
  int                 mismatch_count = 0;
  int                 pixels_checked = 0;
  int                 beats_done     = 0;
  int                 burst_left     = 0;

  bilinear_image_downscaler_unit i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  function automatic int size_in_use(input logic [SIZE_W-1:0] size_val, input int max_size);
    if (size_val == '0) return 1;
    if (int'(size_val) > max_size) return max_size;
    return int'(size_val);
  endfunction

  function automatic void split_axis(input logic [DST_COORD_W-1:0] coord,
                                     input logic [STEP_W-1:0] step_val, input int lim,
                                     output int i0, output int i1,
                                     output logic [FRAC_BITS_DEF-1:0] frac);
    logic [DST_COORD_W+STEP_W-1:0]               pos;
    logic [DST_COORD_W+STEP_W-FRAC_BITS_DEF-1:0] whole;
    pos   = coord * step_val;
    whole = pos[DST_COORD_W+STEP_W-1:FRAC_BITS_DEF];
    frac  = pos[FRAC_BITS_DEF-1:0];
    i0    = (whole >= lim) ? lim - 1 : int'(whole);
    i1    = (i0 + 1 < lim) ? i0 + 1 : i0;
  endfunction

  function automatic logic [PIXEL_W-1:0] blend_pixel(input logic [DST_COORD_W-1:0] dcol,
                                                     input logic [DST_COORD_W-1:0] drow);
    int                       x0, x1, y0, y1;
    logic [FRAC_BITS_DEF-1:0] fx, fy;
    logic [63:0]              w00, w10, w01, w11, acc, lvl;
    logic [PIXEL_W-1:0]       p00, p10, p01, p11, res;
    split_axis(dcol, hstep_copy, size_in_use(width_copy, MAX_WIDTH_DEF), x0, x1, fx);
    split_axis(drow, vstep_copy, size_in_use(height_copy, MAX_HEIGHT_DEF), y0, y1, fy);
    p00 = frame_copy[y0 * MAX_WIDTH_DEF + x0];
    p10 = frame_copy[y0 * MAX_WIDTH_DEF + x1];
    p01 = frame_copy[y1 * MAX_WIDTH_DEF + x0];
    p11 = frame_copy[y1 * MAX_WIDTH_DEF + x1];
    w00 = (UNITY - fx) * (UNITY - fy);
    w10 = fx * (UNITY - fy);
    w01 = (UNITY - fx) * fy;
    w11 = fx * fy;
    res = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      acc = p00[c*CHAN_W +: CHAN_W] * w00 + p10[c*CHAN_W +: CHAN_W] * w10
          + p01[c*CHAN_W +: CHAN_W] * w01 + p11[c*CHAN_W +: CHAN_W] * w11;
      lvl = (acc + HALF) >> (2 * FRAC_BITS_DEF);
      res[c*CHAN_W +: CHAN_W] = (lvl > 64'd255) ? 8'hFF : lvl[CHAN_W-1:0];
    end
    return res;
  endfunction

  function automatic int coord_reach(input logic [STEP_W-1:0] step_val, input int lim);
    longint r;
    if (step_val == '0) return DST_MAX;
    r = (longint'(lim) << FRAC_BITS_DEF) / longint'(step_val) + 1;
    return (r > DST_MAX) ? DST_MAX : int'(r);
  endfunction

  task automatic send_beat(input logic op, input logic [SRC_COORD_W-1:0] scol,
                           input logic [SRC_COORD_W-1:0] srow, input logic [PIXEL_W-1:0] pix,
                           input logic [DST_COORD_W-1:0] dcol,
                           input logic [DST_COORD_W-1:0] drow,
                           input logic has_exp, input logic [PIXEL_W-1:0] exp_pixel);
    int gap;
    int idx;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_op         <= op;
    in_src_col    <= scol;
    in_src_row    <= srow;
    in_pixel_bgra <= pix;
    in_dst_col    <= dcol;
    in_dst_row    <= drow;
    do @(posedge clk); while (!in_ready);
    beats_done++;
    if (op == OP_WRITE) begin
      idx = int'(srow) * MAX_WIDTH_DEF + int'(scol);
      frame_copy[idx]  = pix;
      pix_written[idx] = 1'b1;
    end else begin
      pending_pixels.push_back(has_exp ? exp_pixel : blend_pixel(dcol, drow));
    end
  endtask

  // Any neighbour not yet written is filled first, so that no request reads
  // an undefined store location.
  task automatic request_pixel(input logic [DST_COORD_W-1:0] dcol,
                               input logic [DST_COORD_W-1:0] drow,
                               input logic has_exp, input logic [PIXEL_W-1:0] exp_pixel);
    int                       xs [2];
    int                       ys [2];
    logic [FRAC_BITS_DEF-1:0] fx, fy;
    split_axis(dcol, hstep_copy, size_in_use(width_copy, MAX_WIDTH_DEF), xs[0], xs[1], fx);
    split_axis(drow, vstep_copy, size_in_use(height_copy, MAX_HEIGHT_DEF), ys[0], ys[1], fy);
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < 2; k++) begin
        if (!pix_written[ys[j] * MAX_WIDTH_DEF + xs[k]])
          send_beat(OP_WRITE, SRC_COORD_W'(xs[k]), SRC_COORD_W'(ys[j]), $urandom,
                    DST_COORD_W'($urandom), DST_COORD_W'($urandom), 1'b0, '0);
      end
    end
    send_beat(OP_REQUEST, SRC_COORD_W'($urandom), SRC_COORD_W'($urandom), $urandom,
              dcol, drow, has_exp, exp_pixel);
  endtask

  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_HSTEP: hstep_copy  = val[STEP_W-1:0];
      CFG_VSTEP: vstep_copy  = val[STEP_W-1:0];
      CFG_WIDTH: width_copy  = val[SIZE_W-1:0];
      default:   height_copy = val[SIZE_W-1:0];
    endcase
  endtask

  task automatic run_phase(input logic [STEP_W-1:0] hstep, input logic [STEP_W-1:0] vstep,
                           input logic [SIZE_W-1:0] wsize, input logic [SIZE_W-1:0] hsize,
                           input int beats);
    int start;
    int lim_w, lim_h, reach_c, reach_r;
    settle();
    write_register(CFG_HSTEP, hstep);
    write_register(CFG_VSTEP, vstep);
    write_register(CFG_WIDTH, {16'($urandom), wsize});
    write_register(CFG_HEIGHT, {16'($urandom), hsize});
    cfg_we <= 1'b0;
    lim_w   = size_in_use(wsize, MAX_WIDTH_DEF);
    lim_h   = size_in_use(hsize, MAX_HEIGHT_DEF);
    reach_c = coord_reach(hstep, lim_w);
    reach_r = coord_reach(vstep, lim_h);
    start   = beats_done;
    while (beats_done - start < beats) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 1)
          send_beat(OP_WRITE, SRC_COORD_W'($urandom_range(0, lim_w - 1)),
                    SRC_COORD_W'($urandom_range(0, lim_h - 1)), $urandom,
                    DST_COORD_W'($urandom), DST_COORD_W'($urandom), 1'b0, '0);
        else
          send_beat(OP_WRITE, SRC_COORD_W'($urandom), SRC_COORD_W'($urandom), $urandom,
                    DST_COORD_W'($urandom), DST_COORD_W'($urandom), 1'b0, '0);
      end else if ($urandom_range(0, 3) == 0) begin
        request_pixel(DST_COORD_W'($urandom), DST_COORD_W'($urandom), 1'b0, '0);
      end else begin
        request_pixel(DST_COORD_W'($urandom_range(0, reach_c)),
                      DST_COORD_W'($urandom_range(0, reach_r)), 1'b0, '0);
      end
    end
  endtask

  initial begin
    int hold_left;
    int pattern_pos;
    bit hold_done;
    logic [PIXEL_W-1:0] want;
    hold_left   = 0;
    pattern_pos = 0;
    hold_done   = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: out_pixel %08h arrived with nothing expected", $time, out_pixel);
          mismatch_count++;
        end else begin
          want = pending_pixels.pop_front();
          pixels_checked++;
          if (out_pixel !== want) begin
            $display("%0t: out_pixel mismatch, expected %08h, actual %08h",
                     $time, want, out_pixel);
            mismatch_count++;
          end
        end
      end
      // A single long hold-off lets the output register and the input side back up.
      if (!hold_done && pixels_checked >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        pattern_pos = (pattern_pos + 1) % 40;
        out_ready <= (pattern_pos < 16) || ($urandom_range(0, 1) == 1);
      end
    end
  end

  initial begin
    stim_row_t directed_rows [$];
    stim_row_t row;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_op         <= OP_WRITE;
    in_src_col    <= '0;
    in_src_row    <= '0;
    in_pixel_bgra <= '0;
    in_dst_col    <= '0;
    in_dst_row    <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_HSTEP;
    cfg_data      <= '0;

    directed_rows.push_back(stim_row_t'{ROW_WRITE, 12'd0, 12'd0, 32'h11223344, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_WRITE, 12'd1, 12'd0, 32'hFFFFFFFF, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_WRITE, 12'd0, 12'd1, 32'h00000000, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_WRITE, 12'd1, 12'd1, 32'h80808080, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_WRITE, 12'd127, 12'd127, 32'hA5A55A5A, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_WRITE, 12'd127, 12'd0, 32'h01010101, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_REQUEST, 12'd0, 12'd0, 32'h0, 1'b1, 32'h11223344});
    directed_rows.push_back(stim_row_t'{ROW_REQUEST, 12'd4095, 12'd4095, 32'h0, 1'b1,
                                        32'hA5A55A5A});
    directed_rows.push_back(stim_row_t'{ROW_CONFIG, 12'(CFG_WIDTH), 12'd0, 32'd2, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_CONFIG, 12'(CFG_HEIGHT), 12'd0, 32'd2, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_REQUEST, 12'd1, 12'd1, 32'h0, 1'b1, 32'h80808080});
    directed_rows.push_back(stim_row_t'{ROW_CONFIG, 12'(CFG_HSTEP), 12'd0, 32'h8000, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_CONFIG, 12'(CFG_VSTEP), 12'd0, 32'h8000, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_REQUEST, 12'd1, 12'd1, 32'h0, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_REQUEST, 12'd1, 12'd0, 32'h0, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_CONFIG, 12'(CFG_HSTEP), 12'd0, 32'h0, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_CONFIG, 12'(CFG_VSTEP), 12'd0, 32'h0, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_REQUEST, 12'd4095, 12'd4095, 32'h0, 1'b1,
                                        32'h11223344});
    directed_rows.push_back(stim_row_t'{ROW_CONFIG, 12'(CFG_HSTEP), 12'd0, 32'hFFFFFF, 1'b0,
                                        32'h0});
    directed_rows.push_back(stim_row_t'{ROW_CONFIG, 12'(CFG_WIDTH), 12'd0, 32'd0, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_REQUEST, 12'd4095, 12'd0, 32'h0, 1'b1, 32'h11223344});
    directed_rows.push_back(stim_row_t'{ROW_CONFIG, 12'(CFG_WIDTH), 12'd0, 32'd255, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_CONFIG, 12'(CFG_HEIGHT), 12'd0, 32'd0, 1'b0, 32'h0});
    directed_rows.push_back(stim_row_t'{ROW_REQUEST, 12'd1, 12'd0, 32'h0, 1'b1, 32'h01010101});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      case (row.kind)
        ROW_WRITE: begin
          send_beat(OP_WRITE, row.a[SRC_COORD_W-1:0], row.b[SRC_COORD_W-1:0], row.data,
                    DST_COORD_W'($urandom), DST_COORD_W'($urandom), 1'b0, '0);
        end
        ROW_REQUEST: begin
          request_pixel(row.a, row.b, row.has_exp, row.exp_pixel);
        end
        default: begin
          settle();
          write_register(row.a[CFG_IDX_W-1:0], row.data[CFG_DATA_W-1:0]);
          cfg_we <= 1'b0;
        end
      endcase
    end

    run_phase(24'h010000, 24'h010000, 8'd128, 8'd128, 160);
    run_phase(24'h000000, 24'hFFFFFF, 8'd255, 8'd1, 80);
    run_phase(24'hFFFFFF, 24'h000000, 8'd1, 8'd0, 80);
    run_phase(24'h800000, 24'h800000, 8'd129, 8'd128, 80);
    run_phase(24'h004000, 24'h00C000, 8'd6, 8'd9, 120);
    repeat (4) begin
      run_phase(STEP_W'($urandom_range(0, 24'h03FFFF)), STEP_W'($urandom_range(0, 24'h03FFFF)),
                SIZE_W'($urandom_range(1, 16)), SIZE_W'($urandom_range(1, 16)), 120);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
